/* rtl/npr_pkg.sv */
// Shared types and constants for the nearest palette remap engine.
`default_nettype none

package npr_pkg;

   // Field widths.
   localparam int IdxW   = 8;
   localparam int ChanW  = 8;
   localparam int SqW    = 2 * ChanW;
   localparam int DistW  = 18;
   localparam int EntryW = 3 * ChanW;

   // Both tables always span the full index range.
   localparam int TableDepth = 256;

   // Default number of destination entries covered by a search.
   localparam int PaletteSizeDef = 256;

   // Start value of the running minimum; above any real distance.
   localparam logic [DistW-1:0] DistInit = {DistW{1'b1}};

   // Stream payload widths, padded to whole bytes.
   localparam int ReqDataW = 32;
   localparam int RspDataW = 32;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_REMAP = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_LOOKUP,
      ST_DONE
   } state_type;

   // Control toward the distance unit.
   typedef struct packed {
      logic            clear;
      logic            vld;
      logic [IdxW-1:0] idx;
   } dist_req_type;

endpackage

`default_nettype wire

/* rtl/npr_pal_ram.sv */
// Destination palette memory: one write port, one registered read port.
`default_nettype none

module npr_pal_ram (
   input  wire                         clock,
   input  wire                         we,
   input  wire [npr_pkg::IdxW-1:0]     wr_addr,
   input  wire [npr_pkg::EntryW-1:0]   wr_data,
   input  wire [npr_pkg::IdxW-1:0]     rd_addr,
   output logic [npr_pkg::EntryW-1:0]  rd_data
);
   import npr_pkg::*;

   logic [EntryW-1:0] mem_ff [TableDepth];

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/npr_remap_ram.sv */
// Remap table memory: one write port, one registered read port.
`default_nettype none

module npr_remap_ram (
   input  wire                       clock,
   input  wire                       we,
   input  wire [npr_pkg::IdxW-1:0]   wr_addr,
   input  wire [npr_pkg::IdxW-1:0]   wr_data,
   input  wire [npr_pkg::IdxW-1:0]   rd_addr,
   output logic [npr_pkg::IdxW-1:0]  rd_data
);
   import npr_pkg::*;

   logic [IdxW-1:0] mem_ff [TableDepth];

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/npr_dist_unit.sv */
// Squared RGB distance pipeline with a running minimum.
`default_nettype none

module npr_dist_unit (
   input  wire                          clock,
   input  wire                          reset,
   input  npr_pkg::dist_req_type        dreq,
   input  wire [npr_pkg::EntryW-1:0]    entry,
   input  wire [npr_pkg::ChanW-1:0]     red,
   input  wire [npr_pkg::ChanW-1:0]     green,
   input  wire [npr_pkg::ChanW-1:0]     blue,
   output logic [npr_pkg::IdxW-1:0]     best_idx,
   output logic [npr_pkg::DistW-1:0]    best_dist,
   output logic                         busy
);
   import npr_pkg::*;

   logic [ChanW-1:0] e_red, e_green, e_blue;
   logic [ChanW-1:0] d_red, d_green, d_blue;
   logic [SqW-1:0]   sq_red_in, sq_green_in, sq_blue_in;
   logic [SqW-1:0]   sq_red_ff, sq_green_ff, sq_blue_ff;
   logic             sq_vld_ff;
   logic [IdxW-1:0]  sq_idx_ff;
   logic [DistW-1:0] sum;
   logic [IdxW-1:0]  best_idx_ff;
   logic [DistW-1:0] best_dist_ff;

   // Absolute channel differences and their squares.
   always_comb begin
      e_red   = entry[EntryW-1 -: ChanW];
      e_green = entry[2*ChanW-1 -: ChanW];
      e_blue  = entry[ChanW-1:0];
      d_red   = (red   >= e_red)   ? (red   - e_red)   : (e_red   - red);
      d_green = (green >= e_green) ? (green - e_green) : (e_green - green);
      d_blue  = (blue  >= e_blue)  ? (blue  - e_blue)  : (e_blue  - blue);
      sq_red_in   = SqW'(d_red)   * SqW'(d_red);
      sq_green_in = SqW'(d_green) * SqW'(d_green);
      sq_blue_in  = SqW'(d_blue)  * SqW'(d_blue);
   end

   // Square stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
      end else begin
         sq_vld_ff <= dreq.vld;
      end
      sq_red_ff   <= sq_red_in;
      sq_green_ff <= sq_green_in;
      sq_blue_ff  <= sq_blue_in;
      sq_idx_ff   <= dreq.idx;
   end

   assign sum = DistW'(sq_red_ff) + DistW'(sq_green_ff) + DistW'(sq_blue_ff);

   // Running minimum; strict compare keeps the lowest index on a tie.
   always_ff @(posedge clock) begin
      if (dreq.clear) begin
         best_dist_ff <= DistInit;
         best_idx_ff  <= '0;
      end else if (sq_vld_ff && (sum < best_dist_ff)) begin
         best_dist_ff <= sum;
         best_idx_ff  <= sq_idx_ff;
      end
   end

   assign best_idx  = best_idx_ff;
   assign best_dist = best_dist_ff;
   assign busy      = sq_vld_ff;

endmodule

`default_nettype wire

/* rtl/nearest_palette_remap_core.sv */
// Top level of the nearest palette remap engine.
//
// Items arrive on the req_ stream: tuser carries the opcode, tdata the index
// and the red, green and blue channels. A load item writes one destination
// palette entry and gives no result. A build item reads the destination
// palette from entry 0 up to PALETTE_SIZE-1, one entry per cycle through the
// palette memory read port, keeps the nearest entry in squared RGB distance,
// writes it into the remap table and returns it with its distance. A remap
// item reads the remap table and returns the stored index with a distance of
// zero. The block handles one item at a time; the palette scan sets the
// rate of build items.
// Results leave through an output register on the rsp_ stream. A new item is
// accepted while a result still waits there; if the receiver stalls, the
// next result waits inside until the register frees up.
// Reset returns the control logic to idle and empties the output register;
// the table contents are undefined until written.
`default_nettype none

module nearest_palette_remap_core #(
   parameter int PALETTE_SIZE = npr_pkg::PaletteSizeDef
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   // [7:0] index, [15:8] red, [23:16] green, [31:24] blue
   input  wire [npr_pkg::ReqDataW-1:0]    req_tdata,
   // [1:0] opcode
   input  wire [1:0]                      req_tuser,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   // [7:0] out_index, [25:8] best_distance, [31:26] zero
   output logic [npr_pkg::RspDataW-1:0]   rsp_tdata
);
   import npr_pkg::*;

   localparam int CntW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
   localparam logic [CntW-1:0] CntLast = CntW'(PALETTE_SIZE - 1);

   state_type        state_ff, state_in;
   logic [CntW-1:0]  scan_ff, scan_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IdxW-1:0]  rd_idx_ff;
   logic [IdxW-1:0]  req_idx_ff;
   logic [ChanW-1:0] req_red_ff, req_green_ff, req_blue_ff;
   logic [IdxW-1:0]  res_idx_ff, res_idx_in;
   logic [DistW-1:0] res_dist_ff, res_dist_in;
   logic             rsp_vld_ff, rsp_vld_in;
   logic [RspDataW-1:0] rsp_data_ff, rsp_data_in;

   logic             accept;
   op_type           op;
   logic [IdxW-1:0]  in_idx;
   logic             pal_we;
   logic [EntryW-1:0] pal_rd_data;
   logic             rmp_we;
   logic [IdxW-1:0]  rmp_rd_data;
   logic             drain_done;
   dist_req_type     dreq;
   logic [IdxW-1:0]  best_idx;
   logic [DistW-1:0] best_dist;
   logic             dist_busy;

   assign accept     = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);
   assign in_idx     = req_tdata[IdxW-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign drain_done = (state_ff == ST_DRAIN) && !rd_vld_ff && !dist_busy;
   assign pal_we     = accept && (op == OP_LOAD);
   assign rmp_we     = drain_done;

   // Control toward the distance pipeline.
   always_comb begin
      dreq.clear = accept && (op == OP_BUILD);
      dreq.vld   = rd_vld_ff;
      dreq.idx   = rd_idx_ff;
   end

   npr_pal_ram u_pal_ram (
      .clock   (clock),
      .we      (pal_we),
      .wr_addr (in_idx),
      .wr_data ({req_tdata[2*IdxW-1 -: ChanW], req_tdata[IdxW+2*ChanW-1 -: ChanW],
                 req_tdata[IdxW+3*ChanW-1 -: ChanW]}),
      .rd_addr (IdxW'(scan_ff)),
      .rd_data (pal_rd_data)
   );

   npr_remap_ram u_remap_ram (
      .clock   (clock),
      .we      (rmp_we),
      .wr_addr (req_idx_ff),
      .wr_data (best_idx),
      .rd_addr (in_idx),
      .rd_data (rmp_rd_data)
   );

   npr_dist_unit u_dist (
      .clock     (clock),
      .reset     (reset),
      .dreq      (dreq),
      .entry     (pal_rd_data),
      .red       (req_red_ff),
      .green     (req_green_ff),
      .blue      (req_blue_ff),
      .best_idx  (best_idx),
      .best_dist (best_dist),
      .busy      (dist_busy)
   );

   // Next state, scan counter, result capture and output register.
   always_comb begin
      state_in    = state_ff;
      scan_in     = scan_ff;
      rd_vld_in   = 1'b0;
      res_idx_in  = res_idx_ff;
      res_dist_in = res_dist_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            if (accept) begin
               case (op)
                  OP_BUILD: state_in = ST_SCAN;
                  OP_REMAP: state_in = ST_LOOKUP;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            rd_vld_in = 1'b1;
            scan_in   = scan_ff + 1'b1;
            if (scan_ff == CntLast) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_done) begin
               res_idx_in  = best_idx;
               res_dist_in = best_dist;
               state_in    = ST_DONE;
            end
         end
         ST_LOOKUP: begin
            res_idx_in  = rmp_rd_data;
            res_dist_in = '0;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = RspDataW'({res_dist_ff, res_idx_ff});
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         scan_ff    <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         scan_ff    <= scan_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_idx_ff   <= IdxW'(scan_ff);
      res_idx_ff  <= res_idx_in;
      res_dist_ff <= res_dist_in;
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         req_idx_ff   <= in_idx;
         req_red_ff   <= req_tdata[IdxW+ChanW-1 -: ChanW];
         req_green_ff <= req_tdata[IdxW+2*ChanW-1 -: ChanW];
         req_blue_ff  <= req_tdata[IdxW+3*ChanW-1 -: ChanW];
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A new result only appears after the result has been staged.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

   // The palette never changes under a running search.
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DRAIN) |-> !pal_we)
      else $error("palette written during a search");

   // Once the pipeline is empty the search completes in the next cycle.
   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      drain_done |=> (state_ff == ST_DONE))
      else $error("drain did not hand over to done");

   // A finished search carries a real distance, never the start value.
   a_real_dist: assert property (@(posedge clock) disable iff (reset)
      drain_done |-> (best_dist != DistInit))
      else $error("search ended without any match");

   // No read is in flight once the search has handed over.
   a_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE || state_ff == ST_IDLE) |-> (!rd_vld_ff && !dist_busy))
      else $error("distance pipeline busy outside a search");

endmodule

`default_nettype wire

/* sim/tb_nearest_palette_remap_core.sv */
// Self-checking testbench for the nearest palette remap engine.
`timescale 1ns / 100ps

module tb_nearest_palette_remap_core;
   import npr_pkg::*;

   localparam int          PaletteEntries = PaletteSizeDef;
   localparam logic [1:0]  OpUnused       = 2'd3;
   localparam int          NoMatch        = 32'h7fffffff;
   localparam int          RandomItems    = 1570;
   localparam int          CycleLimit     = 1500000;
   localparam int          DrainCycles    = PaletteEntries + 20;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_item_type;

   typedef struct packed {
      logic [IdxW-1:0]  index;
      logic [DistW-1:0] distance;
   } match_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ReqDataW-1:0]   req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RspDataW-1:0]   rsp_tdata;

   // Stimulus and expectation stores.
   req_item_type          pending_items[$];
   req_item_type          driven_item;
   match_type             expected_matches[$];

   // Predictor state: destination palette and remap table.
   logic [EntryW-1:0]     palette_mem[TableDepth];
   logic [IdxW-1:0]       remap_mem[TableDepth];

   // Generator's view of what has been written so far.
   logic [EntryW-1:0]     gen_palette[TableDepth];
   logic                  gen_remap_ok[TableDepth];
   logic [7:0]            gen_remap_list[$];

   int                    cycle_count  = 0;
   int                    fail_count   = 0;
   int                    n_load       = 0;
   int                    n_build      = 0;
   int                    n_remap      = 0;
   int                    n_unused     = 0;
   int                    n_checked    = 0;

   nearest_palette_remap_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] index, [15:8] red, [23:16] green, [31:24] blue
      .req_tuser  (req_tuser),   // [1:0] opcode
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // [7:0] out_index, [25:8] best_distance, [31:26] zero
   );

   always #6 clock = ~clock;

   // Random idling on both sides, except for one long busy stretch.
   function automatic bit idle_now();
      if (cycle_count >= 20000 && cycle_count < 45000) begin
         return 1'b0;
      end
      return $urandom_range(99) < 36;
   endfunction

   // Queue one item and track which table entries it makes readable.
   task automatic push_item(input logic [1:0] op, input logic [7:0] idx,
                            input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
      req_item_type it;
      it = '{opcode: op, index: idx, red: r, green: g, blue: b};
      pending_items.push_back(it);
      if (op == OP_LOAD) begin
         gen_palette[idx] = {r, g, b};
      end else if (op == OP_BUILD && !gen_remap_ok[idx]) begin
         gen_remap_ok[idx] = 1'b1;
         gen_remap_list.push_back(idx);
      end
   endtask

   // Small random offset around a channel value, kept in range.
   function automatic logic [7:0] nudge(input logic [7:0] v);
      int x;
      x = int'(v) + int'($urandom_range(6)) - 3;
      if (x < 0) x = 0;
      if (x > 255) x = 255;
      return x[7:0];
   endfunction

   // Predict the result of one accepted item and update the tables.
   task automatic remap_predict(input req_item_type it);
      int         best;
      int         sq_dist;
      int         dr;
      int         dg;
      int         db;
      logic [7:0] best_j;
      match_type  m;
      case (it.opcode)
         OP_LOAD: begin
            palette_mem[it.index] = {it.red, it.green, it.blue};
            n_load++;
         end
         OP_BUILD: begin
            best   = NoMatch;
            best_j = '0;
            // Strictly-less compare keeps the lowest index on a tie.
            for (int j = 0; j < PaletteEntries; j++) begin
               dr = int'(it.red)   - int'(palette_mem[j][23:16]);
               dg = int'(it.green) - int'(palette_mem[j][15:8]);
               db = int'(it.blue)  - int'(palette_mem[j][7:0]);
               sq_dist = dr * dr + dg * dg + db * db;
               if (sq_dist < best) begin
                  best   = sq_dist;
                  best_j = j[7:0];
               end
            end
            remap_mem[it.index] = best_j;
            m.index    = best_j;
            m.distance = best[DistW-1:0];
            expected_matches.push_back(m);
            n_build++;
         end
         OP_REMAP: begin
            m.index    = remap_mem[it.index];
            m.distance = '0;
            expected_matches.push_back(m);
            n_remap++;
         end
         default: begin
            n_unused++;
         end
      endcase
   endtask

   // Request driver: holds each item until it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            remap_predict(driven_item);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() > 0 && !idle_now()) begin
               driven_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {driven_item.blue, driven_item.green,
                              driven_item.red, driven_item.index};
               req_tuser  <= driven_item.opcode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      match_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_matches.size() == 0) begin
               $error("unexpected result: out_index %0d best_distance %0d",
                      rsp_tdata[7:0], rsp_tdata[25:8]);
               fail_count++;
            end else begin
               want = expected_matches.pop_front();
               n_checked++;
               if (rsp_tdata[7:0] !== want.index) begin
                  $error("out_index: expected %0d, got %0d", want.index, rsp_tdata[7:0]);
                  fail_count++;
               end
               if (rsp_tdata[25:8] !== want.distance) begin
                  $error("best_distance: expected %0d, got %0d",
                         want.distance, rsp_tdata[25:8]);
                  fail_count++;
               end
               if (rsp_tdata[31:26] !== '0) begin
                  $error("padding: expected 0, got %0d", rsp_tdata[31:26]);
                  fail_count++;
               end
            end
         end
         rsp_tready <= !idle_now();
      end
   end

   // Cycle counter and watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles, %0d results still expected.",
                  cycle_count, expected_matches.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int         roll;
      int         j;
      logic [7:0] idx;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;

      for (int i = 0; i < TableDepth; i++) begin
         gen_remap_ok[i] = 1'b0;
      end

      // Every destination entry is written before any search: all black.
      for (int i = 0; i < TableDepth; i++) begin
         push_item(OP_LOAD, i[7:0], 8'd0, 8'd0, 8'd0);
      end

      // Directed part: extreme distances, ties, every opcode.
      push_item(OP_BUILD, 8'd0,   8'd255, 8'd255, 8'd255);
      push_item(OP_BUILD, 8'd255, 8'd0,   8'd0,   8'd0);
      push_item(OP_REMAP, 8'd0,   8'd255, 8'd255, 8'd255);
      push_item(OP_REMAP, 8'd255, 8'd0,   8'd0,   8'd0);
      push_item(OP_LOAD,  8'd255, 8'd255, 8'd255, 8'd255);
      push_item(OP_LOAD,  8'd128, 8'd255, 8'd0,   8'd0);
      push_item(OP_LOAD,  8'd64,  8'd0,   8'd255, 8'd0);
      push_item(OP_LOAD,  8'd32,  8'd0,   8'd0,   8'd255);
      push_item(OP_LOAD,  8'd200, 8'd0,   8'd0,   8'd255);
      push_item(OP_BUILD, 8'd1,   8'd255, 8'd255, 8'd255);
      push_item(OP_BUILD, 8'd2,   8'd250, 8'd5,   8'd5);
      push_item(OP_BUILD, 8'd3,   8'd0,   8'd0,   8'd250);
      push_item(OP_BUILD, 8'd4,   8'd0,   8'd0,   8'd0);
      push_item(OP_BUILD, 8'd254, 8'd128, 8'd127, 8'd128);
      push_item(OP_BUILD, 8'd170, 8'd0,   8'd250, 8'd3);
      push_item(OP_REMAP, 8'd1,   8'd170, 8'd85,  8'd170);
      push_item(OP_REMAP, 8'd2,   8'd0,   8'd0,   8'd0);
      push_item(OP_REMAP, 8'd3,   8'd255, 8'd255, 8'd255);
      push_item(OP_REMAP, 8'd4,   8'd85,  8'd170, 8'd85);
      push_item(OP_REMAP, 8'd254, 8'd1,   8'd2,   8'd3);
      push_item(OP_REMAP, 8'd170, 8'd9,   8'd9,   8'd9);
      // The unused opcode changes nothing and gives no result.
      push_item(OpUnused, 8'd255, 8'd255, 8'd255, 8'd255);
      push_item(OpUnused, 8'd0,   8'd0,   8'd0,   8'd0);
      push_item(OP_REMAP, 8'd255, 8'd0,   8'd0,   8'd0);

      // Random part: palette updates, searches near and far, lookups, unused opcodes.
      for (int n = 0; n < RandomItems; n++) begin
         roll = $urandom_range(99);
         idx  = $urandom_range(255);
         r    = $urandom_range(255);
         g    = $urandom_range(255);
         b    = $urandom_range(255);
         if (roll < 28) begin
            push_item(OP_LOAD, idx, r, g, b);
         end else if (roll < 52) begin
            // Half of the searches land close to an existing entry.
            if ($urandom_range(1)) begin
               j = $urandom_range(TableDepth - 1);
               r = nudge(gen_palette[j][23:16]);
               g = nudge(gen_palette[j][15:8]);
               b = nudge(gen_palette[j][7:0]);
            end
            push_item(OP_BUILD, idx, r, g, b);
         end else if (roll < 96) begin
            idx = gen_remap_list[$urandom_range(gen_remap_list.size() - 1)];
            push_item(OP_REMAP, idx, r, g, b);
         end else begin
            push_item(OpUnused, idx, r, g, b);
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Wait for all items to go in and all results to come out.
      @(negedge clock);
      while (pending_items.size() > 0 || req_tvalid || expected_matches.size() > 0) begin
         @(negedge clock);
      end
      repeat (DrainCycles) @(negedge clock);

      $display("Run covered %0d palette loads, %0d remap builds, %0d pixel remaps",
               n_load, n_build, n_remap);
      $display("and %0d unused-opcode items; %0d results compared, %0d mismatches.",
               n_unused, n_checked, fail_count);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/npr_pkg.sv
rtl/npr_pal_ram.sv
rtl/npr_remap_ram.sv
rtl/npr_dist_unit.sv
rtl/nearest_palette_remap_core.sv
sim/tb_nearest_palette_remap_core.sv
